### rtl/prjb_pkg.sv
`timescale 1ns / 1ps

package prjb_pkg;

    localparam int SLOTS     = 64;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MAX_DRAIN = 16;
    localparam int WANT_W    = $clog2(MAX_DRAIN + 1);
    localparam int PS_W      = 16;
    localparam int NS_W      = 7;
    localparam int WORD_W    = 64;
    localparam int DIVC_W    = $clog2(WORD_W);
    localparam int PROD_W    = WANT_W + PS_W;
    localparam int IN_W      = 200;
    localparam int OUT_W     = 144;

    localparam logic CFG_PACKET_SIZE  = 1'b0;
    localparam logic CFG_SLOTS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        ACT_PUT     = 2'd0,
        ACT_DRAIN   = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BEHIND     = 2'd1,
        ST_AHEAD      = 2'd2,
        ST_MISALIGNED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DECIDE,
        S_PUSH,
        S_WALK_SETUP,
        S_WALK,
        S_RESULT,
        S_DRAIN_READ,
        S_DRAIN_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic decide;
        logic push;
        logic walk_setup;
        logic walk_step;
        logic result;
        logic drain_read;
        logic drain_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic put_two;
        logic walk_done;
        logic drain_any;
        logic drain_last;
        logic out_busy;
    } stat_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                  input logic [NS_W-1:0] n);
        logic [NS_W-1:0] s;
        s = {{(NS_W-IDX_W){1'b0}}, i} + NS_W'(1);
        return (s == n) ? '0 : s[IDX_W-1:0];
    endfunction

endpackage

### rtl/packet_reorder_jitter_buffer_unit.sv
`timescale 1ns / 1ps

// Reorder buffer over a ring of packet slots. A put is accepted, passed through the
// radix-2 remainder unit that splits the byte offset by packet_size, applied in the
// decide state and, when it takes two slots, the push state, then a walk over the ready
// slots counts the contiguous run, and its result is posted. A drain runs the walk and
// then, for each emitted slot, one memory read and one output load, or posts a result
// when no slot is emitted; a restart or an unused action runs the walk and posts a
// result. Results sit in an output register, so the next item is taken while the last
// one waits; a result that finds the register still full stalls the item in progress
// until the receiver takes the waiting one.
module packet_reorder_jitter_buffer_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // byte_number, payload_word, drain_count, start_byte, zero pad
    input  logic [199:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, slot_payload, slot_filled, ready_count, stored_count, tail_byte
    output logic [143:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    prjb_pkg::cmd_t    cmd;
    prjb_pkg::stat_t   stat;
    prjb_pkg::action_t in_action;

    assign in_action = prjb_pkg::action_t'(s_tuser);

    prjb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (in_action),
        .stat      (stat),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    prjb_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_action (in_action),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/prjb_ctrl.sv
`timescale 1ns / 1ps

module prjb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  prjb_pkg::action_t    in_action,
    input  prjb_pkg::stat_t      stat,
    output logic                 in_ready,
    output prjb_pkg::cmd_t       cmd
);

    prjb_pkg::state_t state_reg;
    prjb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prjb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prjb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_action == prjb_pkg::ACT_PUT) ? prjb_pkg::S_DIV
                                                                  : prjb_pkg::S_WALK_SETUP;
                end
            end
            prjb_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = prjb_pkg::S_DECIDE;
                end
            end
            prjb_pkg::S_DECIDE:
            begin
                state_next = stat.put_two ? prjb_pkg::S_PUSH : prjb_pkg::S_WALK_SETUP;
            end
            prjb_pkg::S_PUSH:
            begin
                state_next = prjb_pkg::S_WALK_SETUP;
            end
            prjb_pkg::S_WALK_SETUP:
            begin
                state_next = prjb_pkg::S_WALK;
            end
            prjb_pkg::S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = stat.drain_any ? prjb_pkg::S_DRAIN_READ : prjb_pkg::S_RESULT;
                end
            end
            prjb_pkg::S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = prjb_pkg::S_IDLE;
                end
            end
            prjb_pkg::S_DRAIN_READ:
            begin
                state_next = prjb_pkg::S_DRAIN_OUT;
            end
            prjb_pkg::S_DRAIN_OUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = stat.drain_last ? prjb_pkg::S_IDLE : prjb_pkg::S_DRAIN_READ;
                end
            end
            default:
            begin
                state_next = prjb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            prjb_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            prjb_pkg::S_DIV:        cmd.div_step   = 1'b1;
            prjb_pkg::S_DECIDE:     cmd.decide     = 1'b1;
            prjb_pkg::S_PUSH:       cmd.push       = 1'b1;
            prjb_pkg::S_WALK_SETUP: cmd.walk_setup = 1'b1;
            prjb_pkg::S_WALK:       cmd.walk_step  = 1'b1;
            prjb_pkg::S_RESULT:     cmd.result     = !stat.out_busy;
            prjb_pkg::S_DRAIN_READ: cmd.drain_read = 1'b1;
            prjb_pkg::S_DRAIN_OUT:  cmd.drain_out  = !stat.out_busy;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/prjb_dp.sv
`timescale 1ns / 1ps

module prjb_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  prjb_pkg::cmd_t                 cmd,
    output prjb_pkg::stat_t                stat,
    input  prjb_pkg::action_t              in_action,
    input  logic [prjb_pkg::IN_W-1:0]      in_data,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [prjb_pkg::PS_W-1:0]      cfg_wdata,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [prjb_pkg::OUT_W-1:0]     out_data,
    output logic                           out_last
);

    localparam int IDX_W  = prjb_pkg::IDX_W;
    localparam int CNT_W  = prjb_pkg::CNT_W;
    localparam int NS_W   = prjb_pkg::NS_W;
    localparam int PS_W   = prjb_pkg::PS_W;
    localparam int WORD_W = prjb_pkg::WORD_W;
    localparam int WANT_W = prjb_pkg::WANT_W;
    localparam int SLOTS  = prjb_pkg::SLOTS;

    // input field split
    logic [WORD_W-1:0] byte_number;
    logic [WORD_W-1:0] payload_word;
    logic [4:0]        drain_count;
    logic [WORD_W-1:0] start_byte;

    assign byte_number  = in_data[63:0];
    assign payload_word = in_data[127:64];
    assign drain_count  = in_data[132:128];
    assign start_byte   = in_data[196:133];

    logic [PS_W-1:0]            ps_reg;
    logic [NS_W-1:0]            ns_reg;
    logic [SLOTS-1:0]           occ_reg;
    logic [SLOTS-1:0]           occ_next;
    logic [IDX_W-1:0]           tail_reg;
    logic [IDX_W-1:0]           tail_next;
    logic [IDX_W-1:0]           head_reg;
    logic [IDX_W-1:0]           head_next;
    logic [IDX_W-1:0]           stored_reg;
    logic [IDX_W-1:0]           stored_next;
    logic [WORD_W-1:0]          head_byte_reg;
    logic [WORD_W-1:0]          head_byte_next;
    logic [WORD_W-1:0]          tail_byte_reg;
    logic [WORD_W-1:0]          tail_byte_next;

    prjb_pkg::action_t          act_reg;
    logic [WORD_W-1:0]          word_reg;
    logic [WANT_W-1:0]          want_reg;
    logic [prjb_pkg::PROD_W-1:0] prod_reg;
    logic [WORD_W-1:0]          dq_reg;
    logic [PS_W-1:0]            rem_reg;
    logic                       neg_reg;
    logic [prjb_pkg::DIVC_W-1:0] divc_reg;
    prjb_pkg::status_t          status_reg;
    logic [IDX_W-1:0]           walk_idx_reg;
    logic [CNT_W-1:0]           walk_k_reg;
    logic [IDX_W-1:0]           walk_lim_reg;
    logic [WORD_W-1:0]          rep_tail_reg;
    logic [WORD_W-1:0]          rd_data_reg;
    logic                       out_valid_reg;
    logic [prjb_pkg::OUT_W-1:0] out_data_reg;
    logic                       out_last_reg;

    logic [WORD_W-1:0] mem [SLOTS];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;

    // derived configuration
    logic [PS_W-1:0] stride;
    logic [NS_W-1:0] n_lim;

    assign stride = (ps_reg == '0) ? PS_W'(1) : ps_reg;
    always_comb
    begin
        if (ns_reg < NS_W'(2))
        begin
            n_lim = NS_W'(2);
        end
        else if (ns_reg > NS_W'(SLOTS))
        begin
            n_lim = NS_W'(SLOTS);
        end
        else
        begin
            n_lim = ns_reg;
        end
    end

    // drain count clamp
    logic [NS_W-1:0]   want_c;
    logic [WANT_W-1:0] want_in;

    always_comb
    begin
        want_c = {2'b00, drain_count};
        if (want_c > NS_W'(prjb_pkg::MAX_DRAIN))
        begin
            want_c = NS_W'(prjb_pkg::MAX_DRAIN);
        end
        if (want_c > {1'b0, stored_reg})
        begin
            want_c = {1'b0, stored_reg};
        end
        want_in = (in_action == prjb_pkg::ACT_DRAIN) ? want_c[WANT_W-1:0] : '0;
    end

    logic [WORD_W-1:0] diff_in;
    assign diff_in = byte_number - tail_byte_reg;

    // one restoring remainder step per cycle
    logic [PS_W:0]   trial;
    logic            trial_ge;
    logic [PS_W:0]   trial_sub;

    assign trial     = {rem_reg, dq_reg[WORD_W-1]};
    assign trial_ge  = trial >= {1'b0, stride};
    assign trial_sub = trial - {1'b0, stride};

    // put decision from quotient and remainder
    logic             q_hi;
    logic [CNT_W-1:0] q_lo;
    logic [CNT_W-1:0] c_ext;
    logic             put_ok;
    logic             put_fill;
    logic             put_one;
    logic             put_two;
    logic [CNT_W-1:0] fill_sum;
    logic [IDX_W-1:0] fill_idx;

    assign q_hi     = |dq_reg[WORD_W-1:CNT_W];
    assign q_lo     = dq_reg[CNT_W-1:0];
    assign c_ext    = {1'b0, stored_reg};
    assign put_ok   = !neg_reg && (rem_reg == '0) && !q_hi;
    assign put_fill = put_ok && (q_lo < c_ext);
    assign put_one  = put_ok && (q_lo == c_ext);
    assign put_two  = put_ok && (q_lo == c_ext + CNT_W'(1));
    assign fill_sum = {1'b0, tail_reg} + q_lo;
    assign fill_idx = (fill_sum >= n_lim) ? IDX_W'(fill_sum - n_lim) : fill_sum[IDX_W-1:0];

    logic push_en;
    logic push_filled;
    logic evict;

    assign push_en     = (cmd.decide && (put_one || put_two)) || cmd.push;
    assign push_filled = cmd.push || (cmd.decide && put_one);
    assign evict       = {1'b0, stored_reg} >= (n_lim - NS_W'(1));

    logic walk_done;
    assign walk_done = !((walk_k_reg < {1'b0, walk_lim_reg}) && occ_reg[walk_idx_reg]);

    logic [CNT_W-1:0] setup_sum;
    logic [IDX_W-1:0] setup_idx;

    assign setup_sum = {1'b0, tail_reg} + CNT_W'(want_reg);
    assign setup_idx = (setup_sum >= n_lim) ? IDX_W'(setup_sum - n_lim) : setup_sum[IDX_W-1:0];

    always_comb
    begin
        occ_next       = occ_reg;
        tail_next      = tail_reg;
        head_next      = head_reg;
        stored_next    = stored_reg;
        head_byte_next = head_byte_reg;
        tail_byte_next = tail_byte_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        if (cfg_we)
        begin
            occ_next       = '0;
            tail_next      = '0;
            head_next      = '0;
            stored_next    = '0;
            tail_byte_next = head_byte_reg;
        end
        else if (cmd.load && (in_action == prjb_pkg::ACT_RESTART))
        begin
            occ_next       = '0;
            tail_next      = '0;
            head_next      = '0;
            stored_next    = '0;
            head_byte_next = start_byte;
            tail_byte_next = start_byte;
        end
        else if (cmd.decide && put_fill)
        begin
            occ_next[fill_idx] = 1'b1;
            mem_we             = 1'b1;
            mem_waddr          = fill_idx;
        end
        else if (push_en)
        begin
            if (evict)
            begin
                occ_next[tail_reg] = 1'b0;
                tail_next          = prjb_pkg::next_idx(tail_reg, n_lim);
                tail_byte_next     = tail_byte_reg + WORD_W'(stride);
            end
            else
            begin
                stored_next = stored_reg + IDX_W'(1);
            end
            occ_next[head_reg] = push_filled;
            mem_we             = push_filled;
            mem_waddr          = head_reg;
            head_next          = prjb_pkg::next_idx(head_reg, n_lim);
            head_byte_next     = head_byte_reg + WORD_W'(stride);
        end
        else if (cmd.drain_out)
        begin
            occ_next[tail_reg] = 1'b0;
            tail_next          = prjb_pkg::next_idx(tail_reg, n_lim);
            stored_next        = stored_reg - IDX_W'(1);
            tail_byte_next     = tail_byte_reg + WORD_W'(stride);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg        <= PS_W'(1);
            ns_reg        <= NS_W'(SLOTS);
            occ_reg       <= '0;
            tail_reg      <= '0;
            head_reg      <= '0;
            stored_reg    <= '0;
            head_byte_reg <= '0;
            tail_byte_reg <= '0;
            divc_reg      <= '0;
            walk_k_reg    <= '0;
            walk_lim_reg  <= '0;
            walk_idx_reg  <= '0;
            want_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == prjb_pkg::CFG_PACKET_SIZE)
                begin
                    ps_reg <= cfg_wdata;
                end
                else
                begin
                    ns_reg <= cfg_wdata[NS_W-1:0];
                end
            end
            occ_reg       <= occ_next;
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            stored_reg    <= stored_next;
            head_byte_reg <= head_byte_next;
            tail_byte_reg <= tail_byte_next;

            if (cmd.load)
            begin
                divc_reg <= '0;
                want_reg <= want_in;
            end
            else if (cmd.div_step)
            begin
                divc_reg <= divc_reg + prjb_pkg::DIVC_W'(1);
            end
            else if (cmd.drain_out)
            begin
                want_reg <= want_reg - WANT_W'(1);
            end

            if (cmd.walk_setup)
            begin
                walk_idx_reg <= setup_idx;
                walk_k_reg   <= '0;
                walk_lim_reg <= stored_reg - IDX_W'(want_reg);
            end
            else if (cmd.walk_step && !walk_done)
            begin
                walk_idx_reg <= prjb_pkg::next_idx(walk_idx_reg, n_lim);
                walk_k_reg   <= walk_k_reg + CNT_W'(1);
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (cmd.result || cmd.drain_out)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // item payload and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= in_action;
            word_reg   <= payload_word;
            dq_reg     <= diff_in;
            neg_reg    <= diff_in[WORD_W-1];
            rem_reg    <= '0;
            status_reg <= prjb_pkg::ST_OK;
            prod_reg   <= want_in * stride;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[WORD_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[PS_W-1:0] : trial[PS_W-1:0];
        end
        else if (cmd.decide)
        begin
            if (neg_reg)
            begin
                status_reg <= prjb_pkg::ST_BEHIND;
            end
            else if (rem_reg != '0)
            begin
                status_reg <= prjb_pkg::ST_MISALIGNED;
            end
            else if (!(put_fill || put_one || put_two))
            begin
                status_reg <= prjb_pkg::ST_AHEAD;
            end
        end
        if (cmd.walk_setup)
        begin
            rep_tail_reg <= tail_byte_reg + WORD_W'(prod_reg);
        end
        if (cmd.result)
        begin
            out_data_reg <= {rep_tail_reg, walk_lim_reg, walk_k_reg, 1'b0,
                             {WORD_W{1'b0}}, status_reg};
            out_last_reg <= 1'b1;
        end
        else if (cmd.drain_out)
        begin
            out_data_reg <= {rep_tail_reg, walk_lim_reg, walk_k_reg, occ_reg[tail_reg],
                             occ_reg[tail_reg] ? rd_data_reg : {WORD_W{1'b0}},
                             prjb_pkg::ST_OK};
            out_last_reg <= (want_reg == WANT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= word_reg;
        end
        if (cmd.drain_read)
        begin
            rd_data_reg <= mem[tail_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    assign stat.div_done   = (divc_reg == '1);
    assign stat.put_two    = put_two;
    assign stat.walk_done  = walk_done;
    assign stat.drain_any  = (act_reg == prjb_pkg::ACT_DRAIN) && (want_reg != '0);
    assign stat.drain_last = (want_reg == WANT_W'(1));
    assign stat.out_busy   = out_valid_reg;

    // ring bookkeeping stays consistent
    logic [CNT_W-1:0] chk_sum;
    logic [IDX_W-1:0] chk_head;

    assign chk_sum  = {1'b0, tail_reg} + {1'b0, stored_reg};
    assign chk_head = (chk_sum >= n_lim) ? IDX_W'(chk_sum - n_lim) : chk_sum[IDX_W-1:0];

    a_stored_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, stored_reg} < n_lim)
        else $error("stored range reaches ring length");

    a_head_matches: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == chk_head)
        else $error("head slot out of step with tail and stored count");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_k_reg <= {1'b0, walk_lim_reg})
        else $error("ready walk passed the stored range");

endmodule
